// ----- rtl/gnn_pkg.sv -----
// ----------------------------------------------------------------------------
// gnn_pkg
// Shared types and constants for the grid nearest-neighbor search block.
// ----------------------------------------------------------------------------
package gnn_pkg;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;
  localparam logic [1:0] CMD_NOP    = 2'd3;

  localparam logic [1:0] REG_COLS = 2'd0;
  localparam logic [1:0] REG_ROWS = 2'd1;
  localparam logic [1:0] REG_SIZE = 2'd2;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,      // capture input item
    OP_DIV,       // one quotient bit step on all four dividers
    OP_DIV_INIT,  // start dividers on current operands
    OP_CELL,      // latch cell bounds / cell index
    OP_INSERT,    // write slot, bump count
    OP_CLR,       // clear one count entry
    OP_SLOT_RD,   // issue slot read
    OP_SLOT_EV,   // evaluate read slot
    OP_NEXT_CELL, // advance scan to next cell
    OP_RESULT     // present result
  } gnn_op_t;

  typedef struct packed {
    gnn_op_t op;
  } gnn_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       div_done;
    logic       cell_ok;     // insert: cell exists and not full
    logic       clr_done;
    logic       slot_last;   // current slot is last of cell (or cell empty)
    logic       cell_empty;
    logic       scan_done;   // current cell is the last cell of the scan
  } gnn_sts_t;

endpackage

// ----- rtl/gnn_ram.sv -----
// ----------------------------------------------------------------------------
// gnn_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module gnn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/gnn_datapath.sv -----
// ----------------------------------------------------------------------------
// gnn_datapath
// Registers, dividers, count/slot stores and distance compare.
// ----------------------------------------------------------------------------
module gnn_datapath #(
  parameter int MAX_CELLS     = 256,
  parameter int CELL_CAPACITY = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  gnn_pkg::gnn_cmd_t  ctl,
  output gnn_pkg::gnn_sts_t  sts,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_idx,
  input  logic [15:0]        cfg_data,
  input  logic [1:0]         i_cmd,
  input  logic [15:0]        i_id,
  input  logic [15:0]        i_x,
  input  logic [15:0]        i_y,
  input  logic [15:0]        i_rad,
  input  logic [31:0]        i_mask,
  output logic               o_found,
  output logic [15:0]        o_id,
  output logic [32:0]        o_dist,
  output logic               o_full
);
  localparam int CW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int KW = (CELL_CAPACITY > 1) ? $clog2(CELL_CAPACITY) : 1;
  localparam int NW = $clog2(CELL_CAPACITY + 1);
  localparam int SW = CW + KW;
  localparam int SLOTS = 1 << SW;

  logic [8:0]  cols_r, rows_r;
  logic [15:0] size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= 9'd16;
      rows_r <= 9'd16;
      size_r <= 16'd1024;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        gnn_pkg::REG_COLS: cols_r <= cfg_data[8:0];
        gnn_pkg::REG_ROWS: rows_r <= cfg_data[8:0];
        gnn_pkg::REG_SIZE: size_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [8:0] cols_e, rows_e;
  logic [15:0] size_e;
  assign cols_e = (cols_r == 9'd0) ? 9'd1 : ((cols_r > 9'd256) ? 9'd256 : cols_r);
  assign rows_e = (rows_r == 9'd0) ? 9'd1 : ((rows_r > 9'd256) ? 9'd256 : rows_r);
  assign size_e = (size_r == 16'd0) ? 16'd1 : size_r;

  logic [1:0]  cmd_r;
  logic [15:0] id_r, x_r, y_r, rad_r;
  logic [31:0] mask_r;

  // four restoring dividers: x_lo, x_hi, y_lo, y_hi (17-bit dividends)
  logic [16:0] dvd_r [4];
  logic [16:0] rem_r [4];
  logic [16:0] quo_r [4];
  logic [4:0]  dcnt_r;
  logic [16:0] dv_init [4];
  logic [17:0] tr [4];

  always_comb begin
    dv_init[0] = (x_r >= rad_r) ? {1'b0, x_r - rad_r} : 17'd0;
    dv_init[1] = {1'b0, x_r} + {1'b0, rad_r};
    dv_init[2] = (y_r >= rad_r) ? {1'b0, y_r - rad_r} : 17'd0;
    dv_init[3] = {1'b0, y_r} + {1'b0, rad_r};
    if (cmd_r == gnn_pkg::CMD_INSERT) begin
      dv_init[0] = {1'b0, x_r};
      dv_init[2] = {1'b0, y_r};
    end
    for (int i = 0; i < 4; i++) begin
      tr[i] = {rem_r[i], dvd_r[i][16]} - {2'b00, size_e};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.op == gnn_pkg::OP_DIV_INIT) begin
      for (int i = 0; i < 4; i++) begin
        dvd_r[i] <= dv_init[i];
        rem_r[i] <= 17'd0;
        quo_r[i] <= 17'd0;
      end
      dcnt_r <= 5'd0;
    end else if (ctl.op == gnn_pkg::OP_DIV && dcnt_r != 5'd17) begin
      for (int i = 0; i < 4; i++) begin
        if (!tr[i][17]) begin
          rem_r[i] <= tr[i][16:0];
          quo_r[i] <= {quo_r[i][15:0], 1'b1};
        end else begin
          rem_r[i] <= {rem_r[i][15:0], dvd_r[i][16]};
          quo_r[i] <= {quo_r[i][15:0], 1'b0};
        end
        dvd_r[i] <= {dvd_r[i][15:0], 1'b0};
      end
      dcnt_r <= dcnt_r + 5'd1;
    end
  end
  assign sts.div_done = (dcnt_r == 5'd17);

  function automatic logic [8:0] clampq(input logic [16:0] q, input logic [8:0] lim);
    logic [16:0] m;
    m = {8'd0, lim} - 17'd1;
    clampq = (q > m) ? m[8:0] : q[8:0];
  endfunction

  logic [8:0] x0_r, x1_r, y1_r, cx_r, cy_r;
  logic [16:0] idx_r;   // row*cols + col
  logic [16:0] rowbase_r;
  logic [KW:0] k_r;
  logic [CW:0] clr_r;
  logic        full_r;

  logic [NW-1:0] cnt_rd;
  logic [NW-1:0] n_rdata;
  logic          idx_ok;
  assign idx_ok = idx_r < 17'(MAX_CELLS);

  logic [16:0] ins_idx;
  assign ins_idx = ({8'd0, clampq(quo_r[2], rows_e)} * {8'd0, cols_e}) +
                   {8'd0, clampq(quo_r[0], cols_e)};

  // slot store
  logic          s_we;
  logic [SW-1:0] s_waddr, s_raddr;
  logic [79:0]   s_wdata, s_rdata;
  assign s_we = (ctl.op == gnn_pkg::OP_INSERT) && sts.cell_ok;
  assign s_waddr = {idx_r[CW-1:0], cnt_rd[KW-1:0]};
  assign s_wdata = {mask_r, y_r, x_r, id_r};
  assign s_raddr = {idx_r[CW-1:0], k_r[KW-1:0]};

  gnn_ram #(.WIDTH(80), .DEPTH(SLOTS)) u_slots (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  // cell counts: read at idx_r, cleared by a sweep of one entry per cycle
  logic          n_we;
  logic [CW-1:0] n_waddr;
  logic [NW-1:0] n_wdata;
  assign n_we    = (ctl.op == gnn_pkg::OP_CLR) || s_we;
  assign n_waddr = (ctl.op == gnn_pkg::OP_CLR) ? clr_r[CW-1:0] : idx_r[CW-1:0];
  assign n_wdata = (ctl.op == gnn_pkg::OP_CLR) ? '0 : cnt_rd + NW'(1);

  gnn_ram #(.WIDTH(NW), .DEPTH(1 << CW)) u_counts (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .raddr(idx_r[CW-1:0]), .rdata(n_rdata)
  );
  assign cnt_rd = idx_ok ? n_rdata : '0;

  assign sts.cell_ok = idx_ok && (cnt_rd < NW'(CELL_CAPACITY));
  assign sts.clr_done = (clr_r == (CW+1)'(MAX_CELLS - 1));
  assign sts.cell_empty = (cnt_rd == '0);
  assign sts.slot_last = ({1'b0, k_r} + (KW+2)'(1)) >= (KW+2)'(cnt_rd);
  assign sts.scan_done = (cx_r == x1_r) && (cy_r == y1_r);
  assign sts.cmd = cmd_r;

  // distance of the slot read in the previous cycle
  logic [15:0] ex, ey, dx, dy;
  logic        mok;
  logic [32:0] d;
  logic [32:0] rsq_r, best_r;
  logic [15:0] bid_r;
  logic        hit_r;
  assign ex  = s_rdata[31:16];
  assign ey  = s_rdata[47:32];
  assign dx  = (ex >= x_r) ? ex - x_r : x_r - ex;
  assign dy  = (ey >= y_r) ? ey - y_r : y_r - ey;
  assign mok = (s_rdata[79:48] & mask_r) == mask_r;
  assign d   = {1'b0, {16'd0, dx} * {16'd0, dx}} + {1'b0, {16'd0, dy} * {16'd0, dy}};

  logic [16:0] nxt_idx;
  logic [8:0]  ncx, ncy;
  logic [16:0] nrow;
  always_comb begin
    ncx = cx_r + 9'd1;
    ncy = cy_r;
    nrow = rowbase_r;
    if (cx_r == x1_r) begin
      ncx = x0_r;
      ncy = cy_r + 9'd1;
      nrow = rowbase_r + {8'd0, cols_e};
    end
    nxt_idx = nrow + {8'd0, ncx};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_found <= 1'b0;
      o_id <= '0;
      o_dist <= '0;
      o_full <= 1'b0;
      hit_r <= 1'b0;
      clr_r <= '0;
      k_r <= '0;
    end else begin
      unique case (ctl.op)
        gnn_pkg::OP_LOAD: begin
          cmd_r <= i_cmd; id_r <= i_id; x_r <= i_x; y_r <= i_y;
          rad_r <= i_rad; mask_r <= i_mask;
          hit_r <= 1'b0; clr_r <= '0; k_r <= '0;
        end
        gnn_pkg::OP_CELL: begin
          x0_r <= clampq(quo_r[0], cols_e);
          x1_r <= clampq(quo_r[1], cols_e);
          y1_r <= clampq(quo_r[3], rows_e);
          cx_r <= clampq(quo_r[0], cols_e);
          cy_r <= clampq(quo_r[2], rows_e);
          rowbase_r <= {8'd0, clampq(quo_r[2], rows_e)} * {8'd0, cols_e};
          idx_r <= ins_idx;
          rsq_r <= {1'b0, {16'd0, rad_r} * {16'd0, rad_r}};
        end
        gnn_pkg::OP_INSERT: full_r <= !sts.cell_ok;
        gnn_pkg::OP_CLR: clr_r <= clr_r + (CW+1)'(1);
        gnn_pkg::OP_SLOT_EV: begin
          if (mok && d <= rsq_r && (!hit_r || d < best_r)) begin
            hit_r <= 1'b1;
            best_r <= d;
            bid_r <= s_rdata[15:0];
          end
          k_r <= k_r + (KW+1)'(1);
        end
        gnn_pkg::OP_NEXT_CELL: begin
          cx_r <= ncx; cy_r <= ncy; rowbase_r <= nrow; idx_r <= nxt_idx; k_r <= '0;
        end
        gnn_pkg::OP_RESULT: begin
          o_full  <= (cmd_r == gnn_pkg::CMD_INSERT) && full_r;
          o_found <= (cmd_r == gnn_pkg::CMD_QUERY) && hit_r;
          o_id    <= ((cmd_r == gnn_pkg::CMD_QUERY) && hit_r) ? bid_r : 16'd0;
          o_dist  <= ((cmd_r == gnn_pkg::CMD_QUERY) && hit_r) ? best_r : 33'd0;
        end
        default: ;
      endcase
    end
  end
endmodule

// ----- rtl/gnn_ctrl.sv -----
// ----------------------------------------------------------------------------
// gnn_ctrl
// Command sequencer: divide, insert, clear sweep and cell/slot scan.
// ----------------------------------------------------------------------------
module gnn_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output gnn_pkg::gnn_cmd_t ctl,
  input  gnn_pkg::gnn_sts_t sts
);
  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DINIT, S_DIV, S_CELL, S_WAIT, S_INS, S_CLR, S_CHK, S_RD, S_EV,
    S_NEXT, S_RES, S_OUT
  } state_t;

  state_t state_r;

  always_comb begin
    ctl.op = gnn_pkg::OP_IDLE;
    unique case (state_r)
      S_INIT:  ctl.op = gnn_pkg::OP_CLR;
      S_IDLE:  ctl.op = in_tvalid ? gnn_pkg::OP_LOAD : gnn_pkg::OP_IDLE;
      S_DINIT: ctl.op = gnn_pkg::OP_DIV_INIT;
      S_DIV:   ctl.op = gnn_pkg::OP_DIV;
      S_CELL:  ctl.op = gnn_pkg::OP_CELL;
      S_INS:   ctl.op = gnn_pkg::OP_INSERT;
      S_CLR:   ctl.op = gnn_pkg::OP_CLR;
      S_RD:    ctl.op = gnn_pkg::OP_SLOT_RD;
      S_EV:    ctl.op = gnn_pkg::OP_SLOT_EV;
      S_NEXT:  ctl.op = gnn_pkg::OP_NEXT_CELL;
      S_RES:   ctl.op = out_tvalid ? gnn_pkg::OP_IDLE : gnn_pkg::OP_RESULT;
      default: ctl.op = gnn_pkg::OP_IDLE;
    endcase
  end

  assign in_tready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      out_tvalid <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) out_tvalid <= 1'b0;
      unique case (state_r)
        S_INIT: if (sts.clr_done) state_r <= S_IDLE;
        S_IDLE: if (in_tvalid) state_r <= S_DINIT;
        S_DINIT: begin
          unique case (sts.cmd)
            gnn_pkg::CMD_CLEAR: state_r <= S_CLR;
            gnn_pkg::CMD_INSERT, gnn_pkg::CMD_QUERY: state_r <= S_DIV;
            default: state_r <= S_RES;
          endcase
        end
        S_DIV: if (sts.div_done) state_r <= S_CELL;
        S_CELL: state_r <= S_WAIT;
        S_WAIT: state_r <= (sts.cmd == gnn_pkg::CMD_INSERT) ? S_INS : S_CHK;
        S_INS: state_r <= S_RES;
        S_CLR: if (sts.clr_done) state_r <= S_RES;
        S_CHK: state_r <= sts.cell_empty ? (sts.scan_done ? S_RES : S_NEXT) : S_RD;
        S_RD: state_r <= S_EV;
        S_EV: state_r <= sts.slot_last ? (sts.scan_done ? S_RES : S_NEXT) : S_RD;
        S_NEXT: state_r <= S_WAIT;
        S_RES: if (!out_tvalid) state_r <= S_OUT;
        S_OUT: begin
          if (!out_tvalid) begin
            out_tvalid <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- rtl/grid_nearest_neighbor_search.sv -----
// ----------------------------------------------------------------------------
// grid_nearest_neighbor_search
// Uniform-grid spatial index: clear, insert and nearest-neighbor query.
//
//   channel  dir  content
//   in_      in   cmd, entity_id, pos_x, pos_y, search_radius, component_mask
//   out_     out  found, nearest_id, nearest_dist_sq, cell_full
//   cfg_     in   register index, write data
//
// One transaction at a time. Insert/query: bit-serial divide by cell_size.
// A query then scans each cell of its window, evaluating every stored slot,
// and steps between cells. Clear sweeps MAX_CELLS counts, one per cycle.
// Reset is synchronous; the same sweep then runs before in_tready rises.
// The result waits in the output register while the next transaction is
// taken; that one stalls before its result until it is free.
// ----------------------------------------------------------------------------
module grid_nearest_neighbor_search #(
  parameter int MAX_CELLS     = 256,
  parameter int CELL_CAPACITY = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // cmd[1:0], entity_id[17:2], pos_x[33:18], pos_y[49:34],
  // search_radius[65:50], component_mask[97:66]
  input  logic [103:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // found[0], nearest_id[16:1], nearest_dist_sq[49:17], cell_full[50]
  output logic [55:0]  out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);
  gnn_pkg::gnn_cmd_t ctl;
  gnn_pkg::gnn_sts_t sts;
  logic        o_found, o_full;
  logic [15:0] o_id;
  logic [32:0] o_dist;

  assign cfg_ready = 1'b1;
  assign out_tdata = {5'd0, o_full, o_dist, o_id, o_found};

  gnn_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .ctl(ctl), .sts(sts)
  );

  gnn_datapath #(.MAX_CELLS(MAX_CELLS), .CELL_CAPACITY(CELL_CAPACITY)) u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .sts(sts),
    .cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_data(cfg_data),
    .i_cmd(in_tdata[1:0]), .i_id(in_tdata[17:2]), .i_x(in_tdata[33:18]),
    .i_y(in_tdata[49:34]), .i_rad(in_tdata[65:50]), .i_mask(in_tdata[97:66]),
    .o_found(o_found), .o_id(o_id), .o_dist(o_dist), .o_full(o_full)
  );
endmodule
